// File: rtl/svp_pkg.sv
package svp_pkg;

	localparam int unsigned TAG_BUFFER_SIZE_DEF = 32;
	localparam int unsigned NUM_W = 31;
	localparam int unsigned CHAR_W = 8;
	localparam int unsigned PRE_LEN_W = 5;
	localparam logic [NUM_W-1:0] NUM_MAX = {NUM_W{1'b1}};

	localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
	localparam logic [CHAR_W-1:0] CH_CR = 8'h0d;
	localparam logic [CHAR_W-1:0] CH_LOW_V = 8'h76;
	localparam logic [CHAR_W-1:0] CH_UP_V = 8'h56;
	localparam logic [CHAR_W-1:0] CH_HYPHEN = 8'h2d;
	localparam logic [CHAR_W-1:0] CH_DOT = 8'h2e;
	localparam logic [CHAR_W-1:0] CH_PLUS = 8'h2b;
	localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE = 8'h39;
	localparam logic [CHAR_W-1:0] CH_LOW_A = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LOW_Z = 8'h7a;
	localparam logic [CHAR_W-1:0] CH_UP_A = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UP_Z = 8'h5a;

	typedef enum logic [2:0] {
		PH_SPACE,
		PH_MAJOR,
		PH_MINOR,
		PH_PATCH,
		PH_TAG,
		PH_SKIP
	} phase_t;

	typedef struct packed {
		phase_t           phase;
		logic [NUM_W-1:0] acc;
		logic [NUM_W-1:0] major_held;
		logic [NUM_W-1:0] minor_held;
		logic             digit_seen;
		logic [1:0]       id_len;
		logic             id_all_digits;
		logic             id_lead_zero;
		logic             error_seen;
	} parse_state_t;

	localparam parse_state_t STATE_RESET = '{
		phase: PH_SPACE,
		acc: '0,
		major_held: '0,
		minor_held: '0,
		digit_seen: 1'b0,
		id_len: 2'd0,
		id_all_digits: 1'b1,
		id_lead_zero: 1'b0,
		error_seen: 1'b0
	};

	typedef struct packed {
		logic                 valid_res;
		logic [NUM_W-1:0]     major_number;
		logic [NUM_W-1:0]     minor_number;
		logic [NUM_W-1:0]     patch_number;
		logic                 has_prerelease;
		logic [PRE_LEN_W-1:0] prerelease_length;
	} parse_result_t;

endpackage

// File: rtl/semver_string_parser_unit.sv
// Channel   | Handshake                  | Payload
// ----------+----------------------------+------------------------------------------
// input     | char_valid / char_ready    | character
// result    | result_valid / result_ready| valid_res, major_number, minor_number,
//           |                            | patch_number, has_prerelease,
//           |                            | prerelease_length
//
// One character per cycle: a beat lands in the input register, and the next cycle
// steps the parse state with one multiply-by-ten-add and a few compares.
// A zero byte loads the result register when it leaves the input register; other
// bytes give no result. Reset returns the parse state to leading whitespace.
// Only a terminator waiting on a full result register stalls the input side.
module semver_string_parser_unit #(
	parameter int unsigned TAG_BUFFER_SIZE = svp_pkg::TAG_BUFFER_SIZE_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           char_valid,
	output logic                           char_ready,
	input  logic [svp_pkg::CHAR_W-1:0]     character,
	output logic                           result_valid,
	input  logic                           result_ready,
	output logic                           valid_res,
	output logic [svp_pkg::NUM_W-1:0]      major_number,
	output logic [svp_pkg::NUM_W-1:0]      minor_number,
	output logic [svp_pkg::NUM_W-1:0]      patch_number,
	output logic                           has_prerelease,
	output logic [svp_pkg::PRE_LEN_W-1:0]  prerelease_length
);

	localparam int unsigned TagW = $clog2(TAG_BUFFER_SIZE);

	logic                          valid_s1;
	logic [svp_pkg::CHAR_W-1:0]    char_s1;
	logic                          advance;
	logic                          is_term;
	svp_pkg::parse_state_t         state_q;
	svp_pkg::parse_state_t         state_nxt;
	logic [TagW-1:0]               tag_len_q;
	logic [TagW-1:0]               tag_len_nxt;
	svp_pkg::parse_result_t        res;
	svp_pkg::parse_result_t        res_q;

	assign is_term = (char_s1 == svp_pkg::CH_NUL);
	// hold a terminator only while the result register is full and not drained
	assign advance = valid_s1 && (!is_term || !result_valid || result_ready);
	assign char_ready = !valid_s1 || advance;

	svp_step #(
		.TAG_BUFFER_SIZE(TAG_BUFFER_SIZE)
	) u_step (
		.character  (char_s1),
		.cur        (state_q),
		.tag_len    (tag_len_q),
		.nxt        (state_nxt),
		.tag_len_nxt(tag_len_nxt),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			state_q <= svp_pkg::STATE_RESET;
			tag_len_q <= '0;
			result_valid <= 1'b0;
		end else begin
			if (char_ready) begin
				valid_s1 <= char_valid;
			end
			if (advance) begin
				if (is_term) begin
					state_q <= svp_pkg::STATE_RESET;
					tag_len_q <= '0;
					result_valid <= 1'b1;
				end else begin
					state_q <= state_nxt;
					tag_len_q <= tag_len_nxt;
					if (result_ready) begin
						result_valid <= 1'b0;
					end
				end
			end else if (result_ready) begin
				result_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (char_ready && char_valid) begin
			char_s1 <= character;
		end
		if (advance && is_term) begin
			res_q <= res;
		end
	end

	assign valid_res = res_q.valid_res;
	assign major_number = res_q.major_number;
	assign minor_number = res_q.minor_number;
	assign patch_number = res_q.patch_number;
	assign has_prerelease = res_q.has_prerelease;
	assign prerelease_length = res_q.prerelease_length;

endmodule

// File: rtl/svp_step.sv
module svp_step #(
	parameter int unsigned TAG_BUFFER_SIZE = svp_pkg::TAG_BUFFER_SIZE_DEF,
	localparam int unsigned TagW = $clog2(TAG_BUFFER_SIZE)
) (
	input  logic [svp_pkg::CHAR_W-1:0] character,
	input  svp_pkg::parse_state_t      cur,
	input  logic [TagW-1:0]            tag_len,
	output svp_pkg::parse_state_t      nxt,
	output logic [TagW-1:0]            tag_len_nxt,
	output svp_pkg::parse_result_t     res
);

	localparam logic [TagW-1:0] TagMax = TagW'(TAG_BUFFER_SIZE - 1);

	logic                        is_blank;
	logic                        is_digit;
	logic                        is_alpha;
	logic                        id_ok;
	logic                        ok;
	logic [svp_pkg::NUM_W+3:0]   prod;
	logic [svp_pkg::NUM_W-1:0]   acc_digit;

	always_comb begin
		is_blank = (character == svp_pkg::CH_SPACE) ||
			(character >= svp_pkg::CH_TAB && character <= svp_pkg::CH_CR);
		is_digit = character >= svp_pkg::CH_ZERO && character <= svp_pkg::CH_NINE;
		is_alpha = (character >= svp_pkg::CH_LOW_A && character <= svp_pkg::CH_LOW_Z) ||
			(character >= svp_pkg::CH_UP_A && character <= svp_pkg::CH_UP_Z);
		id_ok = (cur.id_len != 2'd0) &&
			!(cur.id_all_digits && cur.id_len == 2'd2 && cur.id_lead_zero);

		// acc * 10 + digit, saturated
		prod = {1'b0, cur.acc, 3'b000} + {3'b000, cur.acc, 1'b0} +
			(svp_pkg::NUM_W + 4)'(character[3:0]);
		acc_digit = (prod > (svp_pkg::NUM_W + 4)'(svp_pkg::NUM_MAX)) ?
			svp_pkg::NUM_MAX : prod[svp_pkg::NUM_W-1:0];
	end

	always_comb begin
		nxt = cur;
		tag_len_nxt = tag_len;
		case (cur.phase)
			svp_pkg::PH_SPACE: begin
				if (!is_blank) begin
					nxt.phase = svp_pkg::PH_MAJOR;
					if (character == svp_pkg::CH_LOW_V || character == svp_pkg::CH_UP_V) begin
						nxt.phase = svp_pkg::PH_MAJOR;
					end else if (is_digit) begin
						nxt.acc = acc_digit;
						nxt.digit_seen = 1'b1;
					end else begin
						nxt.error_seen = 1'b1;
						nxt.phase = svp_pkg::PH_SKIP;
					end
				end
			end
			svp_pkg::PH_MAJOR, svp_pkg::PH_MINOR: begin
				if (is_digit) begin
					nxt.acc = acc_digit;
					nxt.digit_seen = 1'b1;
				end else if (character == svp_pkg::CH_DOT && cur.digit_seen) begin
					if (cur.phase == svp_pkg::PH_MAJOR) begin
						nxt.major_held = cur.acc;
						nxt.phase = svp_pkg::PH_MINOR;
					end else begin
						nxt.minor_held = cur.acc;
						nxt.phase = svp_pkg::PH_PATCH;
					end
					nxt.acc = '0;
					nxt.digit_seen = 1'b0;
				end else begin
					nxt.error_seen = 1'b1;
					nxt.phase = svp_pkg::PH_SKIP;
				end
			end
			svp_pkg::PH_PATCH: begin
				if (is_digit) begin
					nxt.acc = acc_digit;
					nxt.digit_seen = 1'b1;
				end else if (cur.digit_seen && character == svp_pkg::CH_HYPHEN) begin
					nxt.phase = svp_pkg::PH_TAG;
					nxt.id_len = 2'd0;
					nxt.id_all_digits = 1'b1;
					nxt.id_lead_zero = 1'b0;
				end else if (cur.digit_seen && (character == svp_pkg::CH_PLUS || is_blank)) begin
					nxt.phase = svp_pkg::PH_SKIP;
				end else begin
					nxt.error_seen = 1'b1;
					nxt.phase = svp_pkg::PH_SKIP;
				end
			end
			svp_pkg::PH_TAG: begin
				if (character == svp_pkg::CH_PLUS) begin
					// build metadata follows: stop checking
					nxt.phase = svp_pkg::PH_SKIP;
					nxt.error_seen = !id_ok;
				end else if (!(is_digit || is_alpha || character == svp_pkg::CH_HYPHEN ||
						character == svp_pkg::CH_DOT)) begin
					nxt.error_seen = 1'b1;
					nxt.phase = svp_pkg::PH_SKIP;
				end else begin
					if (tag_len < TagMax) begin
						tag_len_nxt = tag_len + TagW'(1);
					end
					if (character == svp_pkg::CH_DOT) begin
						if (!id_ok) begin
							nxt.error_seen = 1'b1;
							nxt.phase = svp_pkg::PH_SKIP;
						end else begin
							nxt.id_len = 2'd0;
							nxt.id_all_digits = 1'b1;
							nxt.id_lead_zero = 1'b0;
						end
					end else begin
						if (cur.id_len == 2'd0 && character == svp_pkg::CH_ZERO) begin
							nxt.id_lead_zero = 1'b1;
						end
						if (!is_digit) begin
							nxt.id_all_digits = 1'b0;
						end
						if (cur.id_len != 2'd2) begin
							nxt.id_len = cur.id_len + 2'd1;
						end
					end
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

	always_comb begin
		ok = !cur.error_seen;
		case (cur.phase)
			svp_pkg::PH_SPACE, svp_pkg::PH_MAJOR, svp_pkg::PH_MINOR: ok = 1'b0;
			svp_pkg::PH_PATCH: ok = ok && cur.digit_seen;
			svp_pkg::PH_TAG:   ok = ok && id_ok;
			default:           ok = ok;
		endcase

		res = '0;
		if (ok) begin
			res.valid_res = 1'b1;
			res.major_number = cur.major_held;
			res.minor_number = cur.minor_held;
			res.patch_number = cur.acc;
			res.has_prerelease = (tag_len != '0);
			res.prerelease_length = svp_pkg::PRE_LEN_W'(tag_len);
		end
	end

endmodule
